// ----- rtl/kpd_pkg.sv -----
package kpd_pkg;

  // Matrix size; the input word carries four rows and the maps four columns.
  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 4;
  localparam int PORT_ROWS = 4;
  localparam int MAP_COLS  = 4;
  localparam int ROWS_SCANNED = (ROW_COUNT < PORT_ROWS) ? ROW_COUNT : PORT_ROWS;
  localparam int COLS_SCANNED = (COL_COUNT < MAP_COLS) ? COL_COUNT : MAP_COLS;

  localparam int PORT_W   = 8;
  localparam int BITSEL_W = 3;
  localparam int MAP_W    = 12;
  localparam int DEB_W    = 16;
  localparam int TIME_W   = 32;
  localparam int IDX_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CODE_W   = $clog2(ROW_COUNT * COL_COUNT + 1);

  localparam logic [MAP_W-1:0] ROW_MAP_RST  = 12'd1672;
  localparam logic [MAP_W-1:0] COL_MAP_RST  = 12'd4012;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CODE_W-1:0] NO_KEY      = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_MAP  = 2'd0,
    REG_COL_MAP  = 2'd1,
    REG_DEBOUNCE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PORT_ROWS-1:0][PORT_W-1:0] port;
    logic [PORT_ROWS-1:0]             ok;
    logic [TIME_W-1:0]                now;
  } scan_word_t;

  typedef struct packed {
    logic             key_valid;
    logic [IDX_W-1:0] key_row;
    logic [IDX_W-1:0] key_col;
    logic             bus_fault;
  } key_word_t;

endpackage

// ----- rtl/kpd_if.sv -----
interface kpd_in_if;
  import kpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] row0_port;
  logic [PORT_W-1:0] row1_port;
  logic [PORT_W-1:0] row2_port;
  logic [PORT_W-1:0] row3_port;
  logic              row0_ok;
  logic              row1_ok;
  logic              row2_ok;
  logic              row3_ok;
  logic [TIME_W-1:0] now_ms;

  modport source (
    output valid, row0_port, row1_port, row2_port, row3_port,
           row0_ok, row1_ok, row2_ok, row3_ok, now_ms,
    input  ready
  );
  modport sink (
    input  valid, row0_port, row1_port, row2_port, row3_port,
           row0_ok, row1_ok, row2_ok, row3_ok, now_ms,
    output ready
  );
endinterface

interface kpd_out_if;
  import kpd_pkg::*;

  logic             valid;
  logic             ready;
  logic             key_valid;
  logic [IDX_W-1:0] key_row;
  logic [IDX_W-1:0] key_col;
  logic             bus_fault;

  modport source (
    output valid, key_valid, key_row, key_col, bus_fault,
    input  ready
  );
  modport sink (
    input  valid, key_valid, key_row, key_col, bus_fault,
    output ready
  );
endinterface

// ----- rtl/keypad_scan_debounce.sv -----
// Channel   Dir  Handshake        Word
// in_ch     in   valid/ready      row0..3_port, row0..3_ok, now_ms (one scan pass)
// out_ch    out  valid/ready      key_valid, key_row, key_col, bus_fault
// cfg       in   cfg_we           cfg_index, cfg_data (write only)
//
// One scan word enters per cycle while the result is not stalled; it passes the
// input register, then the key search and debounce compare into the result register.
// The debounce state updates in the result stage, so each word sees the state
// its predecessor left. Reset (rst_n low, synchronous) restores the register
// defaults and clears the key state. A stalled result holds both stages; the
// input stage still takes a word while its slot is empty.
module keypad_scan_debounce (
  input  logic                             clk,
  input  logic                             rst_n,
  kpd_in_if.sink                           in_ch,
  kpd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [kpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import kpd_pkg::*;

  // Configuration. The row map only shapes what is driven on the pins, which
  // happens outside this block, so it needs no storage here.
  logic [MAP_W-1:0] col_map_r;
  logic [DEB_W-1:0] debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_map_r  <= COL_MAP_RST;
      debounce_r <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ROW_MAP:  ;
        REG_COL_MAP:  col_map_r  <= cfg_data[MAP_W-1:0];
        REG_DEBOUNCE: debounce_r <= cfg_data[DEB_W-1:0];
        default:      ;
      endcase
    end
  end

  // Stage handshake: the result stage advances when its slot is free or the
  // sink takes the word; the input stage advances into it.
  logic       s1_valid_r;
  scan_word_t s1_word_r;
  logic       out_valid_r;
  key_word_t  out_word_r;
  logic       s2_take;
  logic       s1_take;

  assign s2_take     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s2_take;
  assign s1_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Capture the scan word; hold it while the result stage is stalled.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_word_r.port <= {in_ch.row3_port, in_ch.row2_port, in_ch.row1_port, in_ch.row0_port};
      s1_word_r.ok   <= {in_ch.row3_ok, in_ch.row2_ok, in_ch.row1_ok, in_ch.row0_ok};
      s1_word_r.now  <= in_ch.now_ms;
    end
  end

  // Priority search: first row in order, first column in order whose sensed
  // port bit is low. Only rows up to and including the hit row count toward
  // the transfer check.
  logic              found;
  logic              any_ok;
  logic [IDX_W-1:0]  hit_row;
  logic [IDX_W-1:0]  hit_col;
  logic [CODE_W-1:0] code;

  always_comb begin
    logic [BITSEL_W-1:0] bsel;
    found   = 1'b0;
    any_ok  = 1'b0;
    hit_row = '0;
    hit_col = '0;
    code    = NO_KEY;
    for (int r = 0; r < ROWS_SCANNED; r++) begin
      if (!found) begin
        any_ok = any_ok | s1_word_r.ok[r];
        for (int c = 0; c < COLS_SCANNED; c++) begin
          bsel = col_map_r[BITSEL_W*c +: BITSEL_W];
          if (!found && !s1_word_r.port[r][bsel]) begin
            found   = 1'b1;
            hit_row = IDX_W'(r);
            hit_col = IDX_W'(c);
            code    = CODE_W'(1 + r * COL_COUNT + c);
          end
        end
      end
    end
  end

  // Debounce state and result.
  logic [CODE_W-1:0] last_code_r, last_code_nxt;
  logic [TIME_W-1:0] change_time_r, change_time_nxt;
  logic              emitted_r, emitted_nxt;
  key_word_t         res_nxt;
  logic [TIME_W-1:0] age;

  assign age = s1_word_r.now - change_time_r;

  always_comb begin
    last_code_nxt   = last_code_r;
    change_time_nxt = change_time_r;
    emitted_nxt     = emitted_r;
    res_nxt         = '0;
    if (!any_ok) begin
      // No good transfer: flag it and hold the state.
      res_nxt.bus_fault = 1'b1;
    end else if (code != last_code_r) begin
      // Key changed: restart the timer.
      last_code_nxt   = code;
      change_time_nxt = s1_word_r.now;
      emitted_nxt     = 1'b0;
    end else if (code != NO_KEY && !emitted_r && age >= TIME_W'(debounce_r)) begin
      // Stable long enough: report once.
      emitted_nxt       = 1'b1;
      res_nxt.key_valid = 1'b1;
      res_nxt.key_row   = hit_row;
      res_nxt.key_col   = hit_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      last_code_r   <= NO_KEY;
      change_time_r <= '0;
      emitted_r     <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        last_code_r   <= last_code_nxt;
        change_time_r <= change_time_nxt;
        emitted_r     <= emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_valid = out_word_r.key_valid;
  assign out_ch.key_row   = out_word_r.key_row;
  assign out_ch.key_col   = out_word_r.key_col;
  assign out_ch.bus_fault = out_word_r.bus_fault;

endmodule

// ----- verif/kpd_scan_checker.sv -----
module kpd_scan_checker
  import kpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  kpd_in_if                     in_mon,
  kpd_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    checked,
  output int                    reports
);

  // Shadow registers and debounce state, kept in step with the block.
  logic [MAP_W-1:0]  row_map_q;
  logic [MAP_W-1:0]  col_map_q;
  logic [DEB_W-1:0]  hold_ms_q;
  logic [CODE_W-1:0] held_code;
  logic [TIME_W-1:0] since_ms;
  logic              emitted;

  key_word_t expected_keys[$];

  // Search the pass for the first pressed key and advance the debounce state.
  function automatic key_word_t scan_pass(input scan_word_t w);
    key_word_t         res;
    logic [CODE_W-1:0] code;
    logic              any_ok;
    logic [IDX_W-1:0]  hit_r;
    logic [IDX_W-1:0]  hit_c;
    res    = '0;
    code   = NO_KEY;
    any_ok = 1'b0;
    hit_r  = '0;
    hit_c  = '0;
    for (int r = 0; r < ROWS_SCANNED; r++) begin
      if (code == NO_KEY) begin
        if (w.ok[r]) any_ok = 1'b1;
        for (int c = 0; c < COLS_SCANNED; c++) begin
          if (code == NO_KEY && !w.port[r][col_map_q[BITSEL_W*c +: BITSEL_W]]) begin
            code  = CODE_W'(1 + r * COL_COUNT + c);
            hit_r = IDX_W'(r);
            hit_c = IDX_W'(c);
          end
        end
      end
    end
    if (!any_ok) begin
      res.bus_fault = 1'b1;
    end else if (code != held_code) begin
      held_code = code;
      since_ms  = w.now;
      emitted   = 1'b0;
    end else if (code != NO_KEY && !emitted &&
                 (w.now - since_ms) >= TIME_W'(hold_ms_q)) begin
      emitted       = 1'b1;
      res.key_valid = 1'b1;
      res.key_row   = hit_r;
      res.key_col   = hit_c;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    key_word_t  got;
    key_word_t  want;
    scan_word_t pass;
    if (!rst_n) begin
      row_map_q = ROW_MAP_RST;
      col_map_q = COL_MAP_RST;
      hold_ms_q = DEBOUNCE_RST;
      held_code = NO_KEY;
      since_ms  = '0;
      emitted   = 1'b0;
      expected_keys.delete();
      errors  = 0;
      checked = 0;
      reports = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_ROW_MAP:  row_map_q = cfg_data[MAP_W-1:0];
          REG_COL_MAP:  col_map_q = cfg_data[MAP_W-1:0];
          REG_DEBOUNCE: hold_ms_q = cfg_data[DEB_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.key_valid = out_mon.key_valid;
        got.key_row   = out_mon.key_row;
        got.key_col   = out_mon.key_col;
        got.bus_fault = out_mon.bus_fault;
        if (expected_keys.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected key word: valid=%0b row=%0d col=%0d fault=%0b",
                     got.key_valid, got.key_row, got.key_col, got.bus_fault);
        end else begin
          want = expected_keys.pop_front();
          checked++;
          if (want.key_valid) reports++;
          if (got.key_valid !== want.key_valid || got.key_row !== want.key_row ||
              got.key_col !== want.key_col || got.bus_fault !== want.bus_fault) begin
            errors++;
            if (errors <= 10)
              $display("key word %0d: expected valid=%0b row=%0d col=%0d fault=%0b, %s",
                       checked, want.key_valid, want.key_row, want.key_col,
                       want.bus_fault,
                       $sformatf("got valid=%0b row=%0d col=%0d fault=%0b",
                                 got.key_valid, got.key_row, got.key_col,
                                 got.bus_fault));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pass.port = {in_mon.row3_port, in_mon.row2_port, in_mon.row1_port, in_mon.row0_port};
        pass.ok   = {in_mon.row3_ok, in_mon.row2_ok, in_mon.row1_ok, in_mon.row0_ok};
        pass.now  = in_mon.now_ms;
        expected_keys.push_back(scan_pass(pass));
      end
    end
    pending = expected_keys.size();
  end

endmodule

// ----- verif/tb_keypad_scan_debounce.sv -----
module tb_keypad_scan_debounce;
  import kpd_pkg::*;

  // Index past the register file; a write there must land nowhere.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending_keys;
  int checked;
  int reports;

  kpd_in_if  scan_ch ();
  kpd_out_if key_ch ();

  keypad_scan_debounce uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (scan_ch),
    .out_ch    (key_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kpd_scan_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (scan_ch),
    .out_mon   (key_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending_keys),
    .checked   (checked),
    .reports   (reports)
  );

  // Stimulus-side view of the registers: shapes presses and time steps only.
  logic [MAP_W-1:0]  col_map_now;
  logic [DEB_W-1:0]  deb_now;
  logic [TIME_W-1:0] ms_now;
  int                sent;
  bit                calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("timed out with %0d key words outstanding", pending_keys);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: drop ready in random bursts between runs with ready held high,
  // and stop stalling once the final phase is under way.
  initial begin
    int n;
    key_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        key_ch.ready <= 1'b0;
        n = $urandom_range(1, 9);
      end else begin
        key_ch.ready <= 1'b1;
        n = $urandom_range(1, 16);
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  // Build a scan word from a 32-bit packed reading (row 0 in the low byte).
  function automatic scan_word_t raw_pass(input logic [31:0] ports, input logic [3:0] ok,
                                          input logic [TIME_W-1:0] t);
    scan_word_t w;
    w.port = ports;
    w.ok   = ok;
    w.now  = t;
    return w;
  endfunction

  // Build a scan word whose first pressed key is (hit_r, hit_c), or none when
  // hit_r is negative. Rows ahead of the hit keep every sensed bit high, the hit
  // row keeps earlier columns high, and everything past the hit is random.
  function automatic scan_word_t make_pass(input int hit_r, input int hit_c,
                                           input logic [3:0] ok, input logic [TIME_W-1:0] t);
    scan_word_t  w;
    logic [7:0]  row_mask;
    logic [7:0]  lead_mask;
    row_mask  = '0;
    lead_mask = '0;
    for (int c = 0; c < COLS_SCANNED; c++) begin
      row_mask[col_map_now[BITSEL_W*c +: BITSEL_W]] = 1'b1;
      if (c < hit_c) lead_mask[col_map_now[BITSEL_W*c +: BITSEL_W]] = 1'b1;
    end
    for (int r = 0; r < PORT_ROWS; r++) begin
      w.port[r] = 8'($urandom);
      if (hit_r < 0 || r < hit_r) begin
        w.port[r] |= row_mask;
      end else if (r == hit_r) begin
        w.port[r] |= lead_mask;
        w.port[r][col_map_now[BITSEL_W*hit_c +: BITSEL_W]] = 1'b0;
      end
    end
    w.ok  = ok;
    w.now = t;
    return w;
  endfunction

  // Present one scan word at the falling edge and hold it until accepted.
  task automatic send_pass(input scan_word_t w);
    @(negedge clk);
    scan_ch.valid     <= 1'b1;
    scan_ch.row0_port <= w.port[0];
    scan_ch.row1_port <= w.port[1];
    scan_ch.row2_port <= w.port[2];
    scan_ch.row3_port <= w.port[3];
    scan_ch.row0_ok   <= w.ok[0];
    scan_ch.row1_ok   <= w.ok[1];
    scan_ch.row2_ok   <= w.ok[2];
    scan_ch.row3_ok   <= w.ok[3];
    scan_ch.now_ms    <= w.now;
    do @(posedge clk); while (!scan_ch.ready);
    sent++;
  endtask

  // Drop valid and hold it low for the span given by n.
  task automatic hold_off(input int n);
    @(negedge clk);
    scan_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and wait until every expected key word has come back.
  task automatic settle();
    @(negedge clk);
    scan_ch.valid <= 1'b0;
    wait (pending_keys == 0);
  endtask

  // One-cycle register write; only call while the block is idle.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COL_MAP) col_map_now = data[MAP_W-1:0];
    else if (idx == REG_DEBOUNCE) deb_now = data;
  endtask

  // Reprogram all registers, then play keystrokes: each one holds a key (or no
  // key) for a random number of passes while time advances in steps scaled to
  // the debounce time, so short holds act as bounce and long ones report.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rmap, input logic [CFG_DATA_W-1:0] cmap,
                           input logic [CFG_DATA_W-1:0] deb, input int count, input bit quiet);
    int         n;
    int         r;
    int         c;
    int         hold;
    logic [3:0] ok;
    settle();
    set_reg(REG_ROW_MAP, rmap);
    set_reg(REG_COL_MAP, cmap);
    set_reg(REG_DEBOUNCE, deb);
    calm = quiet;
    n = 0;
    while (n < count) begin
      r    = ($urandom_range(0, 4) == 0) ? -1 : int'($urandom_range(0, 3));
      c    = $urandom_range(0, 3);
      hold = $urandom_range(1, 12);
      for (int k = 0; k < hold && n < count; k++) begin
        if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
        if (!quiet && $urandom_range(0, 199) == 0) settle();
        if ($urandom_range(0, 63) == 0) ms_now = $urandom();
        else ms_now += $urandom_range(0, deb_now / 3 + 2);
        case ($urandom_range(0, 9))
          0:       ok = 4'h0;
          1, 2:    ok = 4'($urandom);
          default: ok = 4'hF;
        endcase
        send_pass(make_pass(r, c, ok, ms_now));
        n++;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_ROW_MAP;
    cfg_data          = '0;
    scan_ch.valid     = 1'b0;
    scan_ch.row0_port = '1;
    scan_ch.row1_port = '1;
    scan_ch.row2_port = '1;
    scan_ch.row3_port = '1;
    scan_ch.row0_ok   = 1'b0;
    scan_ch.row1_ok   = 1'b0;
    scan_ch.row2_ok   = 1'b0;
    scan_ch.row3_ok   = 1'b0;
    scan_ch.now_ms    = '0;
    col_map_now       = COL_MAP_RST;
    deb_now           = DEBOUNCE_RST;
    ms_now            = '0;
    sent              = 0;
    calm              = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings: sensed bits 4..7, 50 ms debounce.
    // Idle keypad matches the reset key state, so nothing changes.
    send_pass(raw_pass(32'hFFFF_FFFF, 4'hF, 32'd0));
    // Every row failed: bus fault with all ports low and the latest timestamp.
    send_pass(raw_pass(32'h0000_0000, 4'h0, 32'hFFFF_FFFF));
    // Low bits outside the column map are not key presses.
    send_pass(raw_pass(32'hF0F0_F0F0, 4'hF, 32'd5));
    // Press the first key, stay one short of the debounce time, then reach it.
    send_pass(make_pass(0, 0, 4'hF, 32'd10));
    send_pass(make_pass(0, 0, 4'hF, 32'd59));
    send_pass(make_pass(0, 0, 4'hF, 32'd60));
    // Keep holding: a key is reported only once.
    send_pass(make_pass(0, 0, 4'hF, 32'd1000));
    // Only a row past the hit succeeded: bus fault, state must hold.
    send_pass(make_pass(1, 2, 4'b1000, 32'd1001));
    send_pass(make_pass(0, 0, 4'hF, 32'd1002));
    // Last key with only the first row good: still a valid pass.
    send_pass(make_pass(3, 3, 4'b0001, 32'd1003));
    send_pass(make_pass(3, 3, 4'b0001, 32'd1053));
    // Release and keep released: no key is never reported.
    send_pass(raw_pass(32'hFFFF_FFFF, 4'hF, 32'd1060));
    send_pass(raw_pass(32'hFFFF_FFFF, 4'hF, 32'd9000));
    // Age measured across the timestamp wrap.
    send_pass(make_pass(2, 1, 4'hF, 32'hFFFF_FFF0));
    send_pass(make_pass(2, 1, 4'hF, 32'h0000_0021));
    send_pass(make_pass(2, 1, 4'hF, 32'h0000_0022));
    // Everything low: the first key wins.
    send_pass(raw_pass(32'h0000_0000, 4'hF, 32'd100));

    // Zero debounce, then a stray write past the register file that must not
    // disturb it.
    settle();
    set_reg(REG_DEBOUNCE, 16'd0);
    set_reg(REG_SPARE, 16'hFFFF);
    send_pass(make_pass(1, 3, 4'hF, 32'd7));
    send_pass(make_pass(1, 3, 4'hF, 32'd7));
    send_pass(make_pass(3, 0, 4'b0100, 32'd8));
    send_pass(make_pass(3, 0, 4'hF, 32'd8));

    // Random keystrokes across register settings, extremes first; the last
    // phase runs without idling on either side.
    run_phase(16'h0FFF, 16'h0000, 16'd0, 200, 1'b0);
    run_phase(16'h0000, 16'h0FFF, 16'hFFFF, 200, 1'b0);
    run_phase(16'(ROW_MAP_RST), 16'd1672, 16'd1, 200, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)), 250, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 200, 1'b0);
    run_phase(16'(ROW_MAP_RST), 16'(COL_MAP_RST), DEBOUNCE_RST, 200, 1'b1);

    // Drain and let the pipeline run dry before the verdict.
    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d scan words across eight register settings, directed part included.",
             sent);
    $display("Checked %0d key words, %0d of them debounced presses; %0d mismatches.",
             checked, reports, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kpd_pkg.sv
rtl/kpd_if.sv
rtl/keypad_scan_debounce.sv
verif/kpd_scan_checker.sv
verif/tb_keypad_scan_debounce.sv
